// File: rtl/sqlv_pkg.sv
package sqlv_pkg;

    localparam int HISTORY_BYTES_DEF = 6;
    localparam int HISTORY_BYTES_MIN = 6;
    localparam int HISTORY_BYTES_MAX = 10;
    localparam int KEYWORD_LEN       = 6;

    // newest byte in the lowest lane, oldest in the highest
    localparam logic [8*KEYWORD_LEN-1:0] KEYWORD = "VALUES";

    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;

    // result bytes caused by one input beat
    typedef struct packed {
        logic       valid;
        logic       two;
        logic [7:0] byte0;
        logic [7:0] byte1;
    } t_emit;

endpackage

// File: rtl/sqlv_if.sv
interface sqlv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface sqlv_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: rtl/sqlv_parser.sv
module sqlv_parser #(
    parameter int HISTORY_BYTES = sqlv_pkg::HISTORY_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte,
    output sqlv_pkg::t_emit o_emit
);
    import sqlv_pkg::*;

    logic [7:0] r_hist [HISTORY_BYTES];
    logic [7:0] n_hist [HISTORY_BYTES];
    logic       r_values, n_values;
    logic       r_tuple, n_tuple;
    logic       r_string, n_string;
    logic       r_escape, n_escape;
    logic       kw_match;
    t_emit      emit;

    always_comb begin
        n_hist   = r_hist;
        n_values = r_values;
        n_tuple  = r_tuple;
        n_string = r_string;
        n_escape = r_escape;
        emit     = '0;
        kw_match = 1'b1;

        if (!r_values) begin
            for (int i = 0; i < HISTORY_BYTES - 1; i++) begin
                n_hist[i] = r_hist[i + 1];
            end
            n_hist[HISTORY_BYTES - 1] = i_byte;
        end

        // newest KEYWORD_LEN history bytes against the keyword
        for (int i = 0; i < KEYWORD_LEN; i++) begin
            if (n_hist[HISTORY_BYTES - KEYWORD_LEN + i] !=
                KEYWORD[8*(KEYWORD_LEN-1-i) +: 8]) begin
                kw_match = 1'b0;
            end
        end

        priority if (!r_values) begin
            n_values = kw_match;
        end else if (!r_tuple) begin
            if (i_byte == CH_SEMI) begin
                n_values = 1'b0;
            end else if (i_byte == CH_LPAREN) begin
                n_tuple = 1'b1;
            end
        end else if (!r_string) begin
            priority if (i_byte == CH_RPAREN) begin
                emit.valid = 1'b1;
                emit.byte0 = CH_NL;
                n_tuple    = 1'b0;
            end else if (i_byte == CH_COMMA) begin
                emit.valid = 1'b1;
                emit.byte0 = CH_TAB;
            end else if (i_byte == CH_SQUOTE) begin
                n_string = 1'b1;
            end else begin
                emit.valid = 1'b1;
                emit.byte0 = i_byte;
            end
        end else if (r_escape) begin
            n_escape   = 1'b0;
            emit.valid = 1'b1;
            if (i_byte == CH_SQUOTE || i_byte == CH_DQUOTE ||
                i_byte == CH_PERCENT || i_byte == CH_UNDER) begin
                emit.byte0 = i_byte;
            end else begin
                emit.two   = 1'b1;
                emit.byte0 = CH_BSLASH;
                emit.byte1 = i_byte;
            end
        end else begin
            priority if (i_byte == CH_BSLASH) begin
                n_escape = 1'b1;
            end else if (i_byte == CH_SQUOTE) begin
                n_string = 1'b0;
            end else if (i_byte == CH_NL) begin
                emit.valid = 1'b1;
                emit.two   = 1'b1;
                emit.byte0 = CH_BSLASH;
                emit.byte1 = CH_LOWER_N;
            end else if (i_byte == CH_TAB) begin
                emit.valid = 1'b1;
                emit.two   = 1'b1;
                emit.byte0 = CH_BSLASH;
                emit.byte1 = CH_LOWER_T;
            end else begin
                emit.valid = 1'b1;
                emit.byte0 = i_byte;
            end
        end

        if (!i_accept) begin
            emit.valid = 1'b0;
        end
    end

    assign o_emit = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HISTORY_BYTES; i++) begin
                r_hist[i] <= '0;
            end
            r_values <= 1'b0;
            r_tuple  <= 1'b0;
            r_string <= 1'b0;
            r_escape <= 1'b0;
        end else if (i_accept) begin
            r_hist   <= n_hist;
            r_values <= n_values;
            r_tuple  <= n_tuple;
            r_string <= n_string;
            r_escape <= n_escape;
        end
    end

    a_string_in_tuple: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_string |-> (r_tuple && r_values))
        else $error("string open outside a tuple");

    a_escape_in_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_escape |-> r_string)
        else $error("escape pending outside a string");

    a_emit_in_tuple: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.valid |-> (r_tuple && i_accept))
        else $error("output produced outside a tuple");

endmodule

// File: rtl/sqlv_out_queue.sv
module sqlv_out_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sqlv_pkg::t_emit i_emit,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic            o_last
);
    import sqlv_pkg::*;

    // two entries, each holding the one or two bytes of one input beat
    logic [7:0] r_byte0 [2];
    logic [7:0] r_byte1 [2];
    logic       r_two   [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       r_second;
    logic       push;
    logic       pop;
    logic       fire;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_byte  = r_second ? r_byte1[r_rd_ptr] : r_byte0[r_rd_ptr];
    assign o_last  = !r_two[r_rd_ptr] || r_second;
    assign fire    = o_valid && i_ready;
    assign pop     = fire && o_last;
    assign push    = i_emit.valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_byte0[r_wr_ptr] <= i_emit.byte0;
            r_byte1[r_wr_ptr] <= i_emit.byte1;
            r_two[r_wr_ptr]   <= i_emit.two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_second <= 1'b0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (fire) begin
                r_second <= !o_last;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !o_full)
        else $error("push into a full queue");

    a_second_of_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (o_valid && r_two[r_rd_ptr]))
        else $error("second byte pending on a single-byte entry");

endmodule

// File: rtl/sql_values_to_tsv_core.sv
// sql values to tsv filter
// i_in  : one dump byte per beat (in_byte), valid/ready handshake
// o_out : one tsv byte per beat (out_byte); last_of_run marks the final
//         byte produced by one input byte
// an input byte yields zero, one or two output bytes. the parser state
// updates in the cycle the byte is taken, and its output bytes are
// registered in a two-entry queue, from which o_out shows them in order.
// input throughput is one byte per cycle while the queue is not full,
// and the output side moves one byte per cycle, so a stream with two-byte
// expansions is paced by the output port.
// i_in.ready depends only on queue occupancy: bytes keep flowing while
// a result waits, until two results are held; a stalled receiver then
// stops the input with no loss.
// synchronous reset (i_rst_n low) clears the keyword history to zero,
// drops out of values, tuple, string and escape state and empties the
// queue; no bytes are produced on the way out of reset.
module sql_values_to_tsv_core #(
    parameter int HISTORY_BYTES = sqlv_pkg::HISTORY_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sqlv_in_if.sink    i_in,
    sqlv_out_if.source o_out
);
    import sqlv_pkg::*;

    t_emit emit;
    logic  full;
    logic  accept;

    assign i_in.ready = !full;
    assign accept     = i_in.valid && !full;

    sqlv_parser #(
        .HISTORY_BYTES(HISTORY_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_byte  (i_in.in_byte),
        .o_emit  (emit)
    );

    sqlv_out_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_emit (emit),
        .o_full (full),
        .o_valid(o_out.valid),
        .i_ready(o_out.ready),
        .o_byte (o_out.out_byte),
        .o_last (o_out.last_of_run)
    );

endmodule
